>>> sv/btscan_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btscan_pkg
// Shared constants and types for the bencode token scanner.
// ---------------------------------------------------------------------------
package btscan_pkg;

    localparam int NEST_DEPTH_DEFAULT = 32;

    localparam logic [15:0] MAX_STRING_LEN_RST    = 16'd255;
    localparam logic [6:0]  MAX_INTEGER_CHARS_RST = 7'd23;
    localparam logic [6:0]  INT_CHARS_CAP         = 7'd64;
    localparam logic [6:0]  INT_COUNT_SAT         = 7'd127;

    // register indexes
    localparam logic CFG_MAX_STRING_LEN    = 1'b0;
    localparam logic CFG_MAX_INTEGER_CHARS = 1'b1;

    // token kinds
    localparam logic [2:0] KIND_DICT     = 3'd0;
    localparam logic [2:0] KIND_LIST     = 3'd1;
    localparam logic [2:0] KIND_INT_OPEN = 3'd2;
    localparam logic [2:0] KIND_STR_HDR  = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;
    localparam logic [2:0] KIND_INT_CHAR = 3'd5;
    localparam logic [2:0] KIND_STR_CHAR = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_INT_TRUNC = 2'd3;

    // bytes
    localparam logic [7:0] CH_E     = 8'h65; // 'e'
    localparam logic [7:0] CH_I     = 8'h69; // 'i'
    localparam logic [7:0] CH_COLON = 8'h3A; // ':'
    localparam logic [7:0] CH_D     = 8'h64; // 'd'
    localparam logic [7:0] CH_L     = 8'h6C; // 'l'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_INT  = 4'b0010,
        MODE_STR  = 4'b0100,
        MODE_SKIP = 4'b1000
    } scan_mode_t;

endpackage

>>> sv/bencode_token_scanner_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bencode_token_scanner_core
// Byte-wide bencode tokenizer with opener nesting stack.
//
// channel   dir  transfer payload
// s_axis    in   tdata: data_byte, tuser: start_of_stream
// m_axis    out  tdata: token_kind/pos/value, tlast, tuser: skipped/error
// cfg       in   cfg_index, cfg_data (always ready)
//
// One byte per cycle unless the output stalls; each token is registered from its transfer.
// Stack top comes from a registered memory read addressed by next depth,
// with a bypass register covering the cycle after a push.
// Async active-low reset; stack memory is not cleared.
// Output stall holds s_axis_tready low only while a token is still pending.
// ---------------------------------------------------------------------------
module bencode_token_scanner_core #(
    parameter int NEST_DEPTH = btscan_pkg::NEST_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_stream

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [2:0] token_kind, [34:3] token_pos,
                                        // [66:35] token_value, [71:67] zero
    output logic        m_axis_tlast,   // last_of_token
    output logic [2:0]  m_axis_tuser,   // [0] skipped, [2:1] error_code

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int DW = $clog2(NEST_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(NEST_DEPTH);

    // configuration
    logic [15:0] max_string_len_reg;
    logic [6:0]  max_integer_chars_reg;

    // scan state
    btscan_pkg::scan_mode_t mode_reg, mode_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   rem_reg, rem_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [31:0]   pos_reg, pos_next;

    // stack
    logic [31:0]   stack_mem [NEST_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [31:0]   byp_reg;
    logic          use_byp_reg;
    logic [AW-1:0] rd_addr;
    logic [31:0]   stack_top;
    logic          push;

    // output register
    logic        o_valid_reg;
    logic [2:0]  o_kind_reg;
    logic [31:0] o_pos_reg;
    logic [31:0] o_value_reg;
    logic        o_last_reg;
    logic        o_skip_reg;
    logic [1:0]  o_err_reg;

    // per-byte decode
    logic        in_xfer;
    logic        sos;
    logic [7:0]  b;
    btscan_pkg::scan_mode_t mode_c;
    logic [DW-1:0] depth_c;
    logic [31:0] acc_c;
    logic [31:0] rem_c;
    logic [6:0]  cnt_c;
    logic [6:0]  limit;
    logic [6:0]  cnt_inc;
    logic [35:0] acc_mul;
    logic [31:0] rem_dec;
    logic        emit;
    logic [2:0]  e_kind;
    logic [31:0] e_pos;
    logic [31:0] e_value;
    logic        e_last;
    logic        e_skip;
    logic [1:0]  e_err;
    logic        stack_empty;
    logic        stack_full;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !o_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign sos           = s_axis_tuser;
    assign b             = s_axis_tdata;

    assign mode_c  = sos ? btscan_pkg::MODE_IDLE : mode_reg;
    assign depth_c = sos ? '0 : depth_reg;
    assign acc_c   = sos ? '0 : acc_reg;
    assign rem_c   = sos ? '0 : rem_reg;
    assign cnt_c   = sos ? '0 : cnt_reg;
    assign pos_next = in_xfer ? ((sos ? 32'd0 : pos_reg) + 32'd1) : pos_reg;

    assign limit   = (max_integer_chars_reg > btscan_pkg::INT_CHARS_CAP) ?
                     btscan_pkg::INT_CHARS_CAP : max_integer_chars_reg;
    assign cnt_inc = (cnt_c < btscan_pkg::INT_COUNT_SAT) ? cnt_c + 7'd1 : cnt_c;
    assign acc_mul = ({4'd0, acc_c} << 3) + ({4'd0, acc_c} << 1)
                   + {32'd0, b[3:0]};
    assign rem_dec = rem_c - 32'd1;

    assign stack_empty = (depth_c == '0);
    assign stack_full  = (depth_c >= DEPTH_FULL);
    assign stack_top   = use_byp_reg ? byp_reg : rd_data_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        emit       = 1'b0;
        e_kind     = btscan_pkg::KIND_DICT;
        e_pos      = pos_next;
        e_value    = 32'd0;
        e_last     = 1'b0;
        e_skip     = 1'b0;
        e_err      = btscan_pkg::ERR_NONE;

        if (in_xfer)
        begin
            mode_next  = mode_c;
            depth_next = depth_c;
            acc_next   = acc_c;
            rem_next   = rem_c;
            cnt_next   = cnt_c;

            case (mode_c)
                btscan_pkg::MODE_INT:
                begin
                    if (b == btscan_pkg::CH_E)
                    begin
                        mode_next = btscan_pkg::MODE_IDLE;
                        cnt_next  = 7'd0;
                        emit      = 1'b1;
                        e_kind    = btscan_pkg::KIND_END;
                        if (stack_empty)
                        begin
                            e_err = btscan_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_c - DW'(1);
                            e_value    = stack_top;
                            if (cnt_c > limit)
                                e_err = btscan_pkg::ERR_INT_TRUNC;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc <= limit)
                        begin
                            emit    = 1'b1;
                            e_kind  = btscan_pkg::KIND_INT_CHAR;
                            e_value = {24'd0, b};
                        end
                    end
                end
                btscan_pkg::MODE_STR:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                        mode_next = btscan_pkg::MODE_IDLE;
                    emit    = 1'b1;
                    e_kind  = btscan_pkg::KIND_STR_CHAR;
                    e_value = {24'd0, b};
                    e_last  = (rem_dec == 32'd0);
                end
                btscan_pkg::MODE_SKIP:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                        mode_next = btscan_pkg::MODE_IDLE;
                end
                default:
                begin
                    if (b inside {[btscan_pkg::CH_0:btscan_pkg::CH_9]})
                    begin
                        acc_next = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                            : acc_mul[31:0];
                    end
                    else if (b == btscan_pkg::CH_COLON)
                    begin
                        acc_next = 32'd0;
                        rem_next = acc_c;
                        emit     = 1'b1;
                        e_kind   = btscan_pkg::KIND_STR_HDR;
                        e_pos    = pos_next + 32'd1;
                        e_value  = acc_c;
                        if (acc_c == 32'd0)
                        begin
                            e_last = 1'b1;
                        end
                        else if (acc_c > {16'd0, max_string_len_reg})
                        begin
                            mode_next = btscan_pkg::MODE_SKIP;
                            e_last    = 1'b1;
                            e_skip    = 1'b1;
                        end
                        else
                        begin
                            mode_next = btscan_pkg::MODE_STR;
                        end
                    end
                    else if (b == btscan_pkg::CH_E)
                    begin
                        emit   = 1'b1;
                        e_kind = btscan_pkg::KIND_END;
                        if (stack_empty)
                        begin
                            e_err = btscan_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_c - DW'(1);
                            e_value    = stack_top;
                        end
                    end
                    else if (b inside {btscan_pkg::CH_I, btscan_pkg::CH_D,
                                       btscan_pkg::CH_L})
                    begin
                        emit = 1'b1;
                        if (b == btscan_pkg::CH_I)
                        begin
                            acc_next  = 32'd0;
                            cnt_next  = 7'd0;
                            mode_next = btscan_pkg::MODE_INT;
                            e_kind    = btscan_pkg::KIND_INT_OPEN;
                        end
                        else if (b == btscan_pkg::CH_D)
                        begin
                            e_kind = btscan_pkg::KIND_DICT;
                        end
                        else
                        begin
                            e_kind = btscan_pkg::KIND_LIST;
                        end
                        if (stack_full)
                        begin
                            e_err = btscan_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            push       = 1'b1;
                            depth_next = depth_c + DW'(1);
                        end
                    end
                end
            endcase
        end
    end

    // read address tracks the top after this cycle's update
    assign rd_addr = (depth_next == '0) ? '0 : AW'(depth_next - DW'(1));

    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[AW'(depth_c)] <= pos_next;
        rd_data_reg <= stack_mem[rd_addr];
        if (push)
            byp_reg <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_string_len_reg    <= btscan_pkg::MAX_STRING_LEN_RST;
            max_integer_chars_reg <= btscan_pkg::MAX_INTEGER_CHARS_RST;
            mode_reg              <= btscan_pkg::MODE_IDLE;
            depth_reg             <= '0;
            acc_reg               <= '0;
            rem_reg               <= '0;
            cnt_reg               <= '0;
            pos_reg               <= '0;
            use_byp_reg           <= 1'b0;
            o_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    btscan_pkg::CFG_MAX_STRING_LEN:    max_string_len_reg <= cfg_data;
                    btscan_pkg::CFG_MAX_INTEGER_CHARS: max_integer_chars_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            mode_reg    <= mode_next;
            depth_reg   <= depth_next;
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            use_byp_reg <= push;
            if (in_xfer)
                o_valid_reg <= emit;
            else if (m_axis_tready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            o_kind_reg  <= e_kind;
            o_pos_reg   <= e_pos;
            o_value_reg <= e_value;
            o_last_reg  <= e_last;
            o_skip_reg  <= e_skip;
            o_err_reg   <= e_err;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {5'd0, o_value_reg, o_pos_reg, o_kind_reg};
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = {o_err_reg, o_skip_reg};

    // assertions
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond nesting limit");

    a_str_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !sos && mode_reg == btscan_pkg::MODE_STR && rem_reg == 32'd1)
        |=> (mode_reg == btscan_pkg::MODE_IDLE))
        else $error("string content did not end on its last byte");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_err_reg == btscan_pkg::ERR_OVERFLOW)
        |-> (depth_reg == DEPTH_FULL))
        else $error("overflow reported with stack not full");

    a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (depth_reg != '0 && use_byp_reg))
        else $error("push did not raise depth");

endmodule
